@@ design/rls_pkg.sv @@
// Package for the remote link supervisor.
// Holds result kinds, command modes, key masks and the job record passed
// from the front end to the back end. No dependencies.
package rls_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int NUM_KEYS = 5;
    localparam int WORD_W = 40;

    localparam logic [2:0] KIND_PING = 3'd0;
    localparam logic [2:0] KIND_CONNECTED = 3'd1;
    localparam logic [2:0] KIND_DISCONNECTED = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_KEY = 3'd4;
    localparam logic [2:0] KIND_WAKE = 3'd5;
    localparam logic [2:0] KIND_RADIO = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    localparam logic [7:0] BYTE_PONG = 8'hf8;
    localparam logic [7:0] BYTE_CONNECT = 8'h56;
    localparam logic [7:0] BYTE_KEY = 8'h4b;
    localparam logic [7:0] BYTE_RADIO = 8'h52;

    localparam logic [15:0] GAP_MAX = 16'hffff;

    localparam logic REG_IDLE_LIMIT = 1'b0;
    localparam logic REG_PING_LIMIT = 1'b1;

    localparam logic [7:0] KEY_BITS [NUM_KEYS] = '{8'h08, 8'h40, 8'h04, 8'h01, 8'h02};

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_KEY     = 4'b0010,
        MODE_RADIO   = 4'b0100,
        MODE_AFTER_V = 4'b1000
    } t_mode;

    // One job expands into one result per set bit of mask, lowest bit first.
    typedef struct packed {
        logic [2:0]          kind;
        logic                with_timeout;
        logic [NUM_KEYS-1:0] mask;
        logic [WORD_W-1:0]   radio_word;
        logic [7:0]          byte_value;
    } t_job;

endpackage

@@ design/remote_link_supervisor.sv @@
// Top level of the remote link supervisor: front end, job queue, back end.
// Depends on rls_pkg, rls_front, rls_queue and rls_back.
//
// One poll is accepted per clock while o_full is low; the front end updates
// the link state in that same cycle and, if the poll causes results, pushes
// one job into a four-entry queue. The back end turns a job into one to five
// result transactions at one per cycle while the output register is empty or
// being popped; only a result waiting in the output register holds the drain,
// and o_full rises only when four jobs are waiting behind it.
module remote_link_supervisor import rls_pkg::*; #(
    parameter int RADIO_BYTES = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [0:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_display_on,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [2:0]        o_kind,
    output logic [2:0]        o_key_index,
    output logic [WORD_W-1:0] o_radio_word,
    output logic [7:0]        o_byte_value,
    output logic              o_last
);

    logic accept;
    logic front_valid;
    t_job front_job;
    logic head_valid;
    t_job head_job;
    logic head_pop;

    assign accept = i_push && !o_full;

    rls_front #(
        .RADIO_BYTES(RADIO_BYTES)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(accept),
        .i_op(i_op),
        .i_rx_byte(i_rx_byte),
        .i_display_on(i_display_on),
        .o_job_valid(front_valid),
        .o_job(front_job)
    );

    rls_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(front_valid),
        .i_job(front_job),
        .o_full(o_full),
        .i_pop(head_pop),
        .o_valid(head_valid),
        .o_job(head_job)
    );

    rls_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(head_valid),
        .i_job(head_job),
        .o_job_pop(head_pop),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_kind(o_kind),
        .o_key_index(o_key_index),
        .o_radio_word(o_radio_word),
        .o_byte_value(o_byte_value),
        .o_last(o_last)
    );

endmodule

@@ design/rls_front.sv @@
// Front end of the remote link supervisor: link state, configuration and
// per-poll classification into jobs. Depends on rls_pkg.
module rls_front import rls_pkg::*; #(
    parameter int RADIO_BYTES = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  logic       i_display_on,
    output logic       o_job_valid,
    output t_job       o_job
);

    localparam int CNT_W = $clog2(RADIO_BYTES + 1);

    logic [7:0]        r_idle_limit;
    logic [3:0]        r_ping_limit;
    logic              r_link_up, n_link_up;
    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_radio_count, n_radio_count;
    logic [WORD_W-1:0] r_radio_bytes, n_radio_bytes;
    logic [7:0]        r_idle_polls, n_idle_polls;
    logic [3:0]        r_pings_sent, n_pings_sent;
    logic              r_pong_seen, n_pong_seen;
    logic              r_ping_pending, n_ping_pending;
    logic [15:0]       r_pong_gap, n_pong_gap;
    logic [15:0]       r_min_gap, n_min_gap;

    logic [15:0]         gap_inc;
    logic [NUM_KEYS-1:0] key_hits;
    logic [WORD_W-1:0]   radio_shift;
    logic [CNT_W-1:0]    radio_inc;

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_hits[i] = |(i_rx_byte & KEY_BITS[i]);
        end
        gap_inc = (r_pong_gap == GAP_MAX) ? r_pong_gap : r_pong_gap + 16'd1;
        radio_shift = {r_radio_bytes[WORD_W-9:0], i_rx_byte};
        radio_inc = r_radio_count + CNT_W'(1);
    end

    always_comb begin
        n_link_up = r_link_up;
        n_mode = r_mode;
        n_radio_count = r_radio_count;
        n_radio_bytes = r_radio_bytes;
        n_idle_polls = r_idle_polls;
        n_pings_sent = r_pings_sent;
        n_pong_seen = r_pong_seen;
        n_ping_pending = r_ping_pending;
        n_pong_gap = r_pong_gap;
        n_min_gap = r_min_gap;
        o_job_valid = 1'b0;
        o_job.kind = KIND_PING;
        o_job.with_timeout = 1'b0;
        o_job.mask = NUM_KEYS'(1);
        o_job.radio_word = '0;
        o_job.byte_value = '0;

        if (!r_link_up) begin
            if (i_op) begin
                n_pong_seen = 1'b0;
                if (i_rx_byte == BYTE_PONG) begin
                    n_pong_seen = 1'b1;
                    n_ping_pending = 1'b0;
                    if (r_pong_gap < r_min_gap) begin
                        n_min_gap = r_pong_gap;
                    end
                    n_pong_gap = '0;
                end else if (i_rx_byte == BYTE_CONNECT) begin
                    n_link_up = 1'b1;
                    n_min_gap = GAP_MAX;
                    n_pings_sent = '0;
                    n_mode = MODE_AFTER_V;
                    o_job_valid = 1'b1;
                    o_job.kind = KIND_CONNECTED;
                end
            end else if (r_pong_seen) begin
                n_pong_gap = gap_inc;
                if (gap_inc > r_min_gap && !r_ping_pending) begin
                    n_ping_pending = 1'b1;
                    o_job_valid = 1'b1;
                    o_job.kind = KIND_PING;
                end
            end
        end else if (i_op) begin
            n_idle_polls = '0;
            n_pings_sent = '0;
            if (i_rx_byte == BYTE_PONG) begin
                n_link_up = 1'b0;
                n_min_gap = GAP_MAX;
                o_job_valid = 1'b1;
                o_job.kind = KIND_DISCONNECTED;
            end else if (i_rx_byte == BYTE_CONNECT) begin
                n_mode = MODE_AFTER_V;
            end else if (i_rx_byte == BYTE_KEY) begin
                n_mode = MODE_KEY;
                n_radio_count = '0;
            end else if (i_rx_byte == BYTE_RADIO) begin
                n_mode = MODE_RADIO;
                n_radio_count = '0;
                n_radio_bytes = '0;
            end else begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        o_job_valid = 1'b1;
                        o_job.kind = KIND_UNKNOWN;
                        o_job.byte_value = i_rx_byte;
                    end
                    MODE_KEY: begin
                        n_mode = MODE_IDLE;
                        if (|key_hits) begin
                            o_job_valid = 1'b1;
                            if (!i_display_on) begin
                                o_job.kind = KIND_WAKE;
                            end else begin
                                o_job.kind = KIND_KEY;
                                o_job.mask = key_hits;
                            end
                        end
                    end
                    MODE_RADIO: begin
                        n_radio_bytes = radio_shift;
                        n_radio_count = radio_inc;
                        if (32'(radio_inc) >= RADIO_BYTES) begin
                            n_radio_count = '0;
                            n_mode = MODE_IDLE;
                            o_job_valid = 1'b1;
                            o_job.kind = KIND_RADIO;
                            o_job.radio_word = radio_shift;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        end else begin
            if (r_idle_polls >= r_idle_limit) begin
                n_idle_polls = '0;
                o_job_valid = 1'b1;
                o_job.kind = KIND_PING;
                if (r_pings_sent >= r_ping_limit) begin
                    n_link_up = 1'b0;
                    n_min_gap = GAP_MAX;
                    n_pings_sent = '0;
                    o_job.with_timeout = 1'b1;
                    o_job.mask = NUM_KEYS'(3);
                end else begin
                    n_pings_sent = r_pings_sent + 4'd1;
                end
            end else begin
                n_idle_polls = r_idle_polls + 8'd1;
            end
        end

        if (!i_valid) begin
            o_job_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= 8'd5;
            r_ping_limit <= 4'd3;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_IDLE_LIMIT) begin
                r_idle_limit <= i_cfg_data;
            end else if (i_cfg_index == REG_PING_LIMIT) begin
                r_ping_limit <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up <= 1'b0;
            r_mode <= MODE_IDLE;
            r_radio_count <= '0;
            r_radio_bytes <= '0;
            r_idle_polls <= '0;
            r_pings_sent <= '0;
            r_pong_seen <= 1'b0;
            r_ping_pending <= 1'b0;
            r_pong_gap <= '0;
            r_min_gap <= GAP_MAX;
        end else if (i_valid) begin
            r_link_up <= n_link_up;
            r_mode <= n_mode;
            r_radio_count <= n_radio_count;
            r_radio_bytes <= n_radio_bytes;
            r_idle_polls <= n_idle_polls;
            r_pings_sent <= n_pings_sent;
            r_pong_seen <= n_pong_seen;
            r_ping_pending <= n_ping_pending;
            r_pong_gap <= n_pong_gap;
            r_min_gap <= n_min_gap;
        end
    end

endmodule

@@ design/rls_queue.sv @@
// Small job queue between the front end and the back end.
// Depends on rls_pkg for the job record and the depth.
module rls_queue import rls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ design/rls_back.sv @@
// Back end of the remote link supervisor (uses rls_pkg): expands each job
// into the output register, one result per cycle while it is free or popped.
module rls_back import rls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_job_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [2:0]        o_kind,
    output logic [2:0]        o_key_index,
    output logic [WORD_W-1:0] o_radio_word,
    output logic [7:0]        o_byte_value,
    output logic              o_last
);

    logic                r_active;
    logic [NUM_KEYS-1:0] r_rem;
    logic                r_out_valid;

    logic [NUM_KEYS-1:0] eff;
    logic [NUM_KEYS-1:0] low;
    logic [NUM_KEYS-1:0] rest;
    logic [2:0]          idx;
    logic [2:0]          kind;
    logic                last;
    logic                step;

    always_comb begin
        eff = r_active ? r_rem : i_job.mask;
        low = eff & (~eff + NUM_KEYS'(1));
        rest = eff & ~low;
        last = (rest == '0);
        idx = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (low[i]) begin
                idx = 3'(i);
            end
        end
        if (i_job.kind == KIND_KEY) begin
            kind = KIND_KEY;
        end else if (i_job.with_timeout && low[1]) begin
            kind = KIND_TIMEOUT;
        end else begin
            kind = i_job.kind;
        end
        step = i_job_valid && (!r_out_valid || i_pop);
    end

    assign o_job_pop = step && last;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (step) begin
            o_kind <= kind;
            o_key_index <= (kind == KIND_KEY) ? idx : 3'd0;
            o_radio_word <= i_job.radio_word;
            o_byte_value <= i_job.byte_value;
            o_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rem <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
                r_active <= !last;
                r_rem <= rest;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ design/rls_checker.sv @@
// Port-level checker for the remote link supervisor and its bind statement.
// Depends on rls_pkg and remote_link_supervisor.
module rls_checker import rls_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_empty,
    input logic              i_pop,
    input logic [2:0]        o_kind,
    input logic [2:0]        o_key_index,
    input logic [WORD_W-1:0] o_radio_word,
    input logic [7:0]        o_byte_value,
    input logic              o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("Result queue not empty after reset.");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_kind == KIND_CONNECTED || o_kind == KIND_DISCONNECTED ||
            o_kind == KIND_TIMEOUT || o_kind == KIND_WAKE ||
            o_kind == KIND_RADIO || o_kind == KIND_UNKNOWN)) |-> o_last)
        else $error("Single-result kind without last flag.");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_kind == KIND_KEY || o_key_index == 3'd0) &&
            (o_kind == KIND_RADIO || o_radio_word == '0) &&
            (o_kind == KIND_UNKNOWN || o_byte_value == 8'd0)))
        else $error("Unused result field is not zero.");

    a_ping_then_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_kind == KIND_PING && !o_last) |=>
            (!o_empty && o_kind == KIND_TIMEOUT && o_last))
        else $error("Ping without last flag not followed by timeout.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_kind) && $stable(o_last)))
        else $error("Waiting result changed before it was taken.");

endmodule

bind remote_link_supervisor rls_checker u_rls_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_empty(o_empty),
    .i_pop(i_pop),
    .o_kind(o_kind),
    .o_key_index(o_key_index),
    .o_radio_word(o_radio_word),
    .o_byte_value(o_byte_value),
    .o_last(o_last)
);
